// ----- sv/bcch_sched_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcch_sched_pkg
// Shared codes for the BCCH system information scheduler: TC slot codes,
// result kinds, optional type mask bits, widths and the rotation step.
// ----------------------------------------------------------------------------
package bcch_sched_pkg;

  localparam int unsigned TC_W   = 3;
  localparam int unsigned KIND_W = 4;
  localparam int unsigned MASK_W = 5;
  localparam int unsigned ROT_W  = 2;

  typedef logic [TC_W-1:0]   tc_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [MASK_W-1:0] mask_t;
  typedef logic [ROT_W-1:0]  rot_t;
  typedef logic [2:0]        list_len_t;

  // system information kind codes
  localparam kind_t KIND_SI1      = 4'd0;
  localparam kind_t KIND_SI2      = 4'd1;
  localparam kind_t KIND_SI2BIS   = 4'd2;
  localparam kind_t KIND_SI2TER   = 4'd3;
  localparam kind_t KIND_SI2QUATER = 4'd4;
  localparam kind_t KIND_SI3      = 4'd5;
  localparam kind_t KIND_SI4      = 4'd6;
  localparam kind_t KIND_SI9      = 4'd7;
  localparam kind_t KIND_SI13     = 4'd8;

  // TC slot codes
  localparam tc_t TC_SI1      = 3'd0;
  localparam tc_t TC_SI2      = 3'd1;
  localparam tc_t TC_SI3      = 3'd2;
  localparam tc_t TC_SI4      = 3'd3;
  localparam tc_t TC_ROTATE   = 3'd4;
  localparam tc_t TC_SI2X     = 3'd5;
  localparam tc_t TC_SI3_ALT  = 3'd6;
  localparam tc_t TC_SI4_ALT  = 3'd7;

  // optional type mask bit positions
  localparam int unsigned BIT_2BIS    = 0;
  localparam int unsigned BIT_2TER    = 1;
  localparam int unsigned BIT_2QUATER = 2;
  localparam int unsigned BIT_9       = 3;
  localparam int unsigned BIT_13      = 4;

  // next rotation position: (idx + 1) mod len, len from 1 to 4
  function automatic rot_t rot_advance(input rot_t idx, input list_len_t len);
    logic [2:0] s;
    rot_t       r;
    s = {1'b0, idx} + 3'd1;
    unique case (len)
      3'd1:    r = '0;
      3'd2:    r = {1'b0, s[0]};
      3'd3:    r = (s == 3'd3) ? 2'd0 : ((s == 3'd4) ? 2'd1 : s[1:0]);
      default: r = s[1:0];
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/bcch_sysinfo_scheduler_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcch_sysinfo_scheduler_core
// Picks the system information type for each BCCH block slot from its TC.
// ----------------------------------------------------------------------------
// One TC value goes in per transfer and one result comes out per transfer,
// in order. A slot passes through an input register and then a result
// register, where it can be taken, and a new slot can be taken every cycle
// while the result side is not stalled; the TC 4 rotation position is
// updated as a slot moves into the result register, so consecutive TC 4
// slots rotate without gaps. The optional type mask is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while no slot is in
// flight, as the block itself does not enforce this. A TC 5 slot with none
// of SI2bis, SI2ter or SI2quater present returns out_none_flag high and out_si_kind zero.
module bcch_sysinfo_scheduler_core (
  input  wire                         clk,
  input  wire                         rst_n,
  // slot input
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  bcch_sched_pkg::tc_t   in_tc,
  // result output
  output logic                        out_valid,
  input  wire                         out_stall,
  output bcch_sched_pkg::kind_t       out_si_kind,
  output logic                        out_none_flag,
  // configuration
  input  wire                         cfg_wr_en,
  input  wire  bcch_sched_pkg::mask_t cfg_wr_data
);
  import bcch_sched_pkg::*;

  logic      s1_valid_r;
  tc_t       s1_tc_r;
  logic      out_valid_r;
  kind_t     out_kind_r;
  logic      out_none_r;
  mask_t     mask_r;
  rot_t      rot_r;
  rot_t      rot_nxt;
  logic      adv;
  logic      s1_move;
  kind_t     kind_nxt;
  logic      none_nxt;
  kind_t     list [4];
  list_len_t list_len;

  // pipeline advance: result register free or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_wr_en) begin
      mask_r <= cfg_wr_data;
    end
  end

  // ordered list of optional types for the TC 4 rotation
  always_comb begin
    logic has_bis;
    logic has_ter;
    has_bis  = mask_r[BIT_2BIS];
    has_ter  = mask_r[BIT_2TER];
    list[0]  = KIND_SI2;
    list[1]  = KIND_SI2;
    list[2]  = KIND_SI2;
    list[3]  = KIND_SI2;
    list_len = '0;
    if (has_ter && has_bis) begin
      list[list_len[1:0]] = KIND_SI2TER;
      list_len            = list_len + 3'd1;
    end
    if (mask_r[BIT_2QUATER] && (has_bis || has_ter)) begin
      list[list_len[1:0]] = KIND_SI2QUATER;
      list_len            = list_len + 3'd1;
    end
    if (mask_r[BIT_13]) begin
      list[list_len[1:0]] = KIND_SI13;
      list_len            = list_len + 3'd1;
    end
    if (mask_r[BIT_9]) begin
      list[list_len[1:0]] = KIND_SI9;
      list_len            = list_len + 3'd1;
    end
  end

  // kind selection for the slot in the input register
  always_comb begin
    rot_t rot_step;
    rot_step = rot_advance(rot_r, list_len);
    kind_nxt = KIND_SI1;
    none_nxt = 1'b0;
    rot_nxt  = rot_r;
    unique case (s1_tc_r)
      TC_SI1:     kind_nxt = KIND_SI1;
      TC_SI2:     kind_nxt = KIND_SI2;
      TC_SI3:     kind_nxt = KIND_SI3;
      TC_SI4:     kind_nxt = KIND_SI4;
      TC_ROTATE: begin
        if (list_len == '0) begin
          kind_nxt = KIND_SI2;
        end else begin
          rot_nxt  = rot_step;
          kind_nxt = list[rot_step];
        end
      end
      TC_SI2X: begin
        priority if (mask_r[BIT_2BIS]) begin
          kind_nxt = KIND_SI2BIS;
        end else if (mask_r[BIT_2TER]) begin
          kind_nxt = KIND_SI2TER;
        end else if (mask_r[BIT_2QUATER]) begin
          kind_nxt = KIND_SI2QUATER;
        end else begin
          none_nxt = 1'b1;
        end
      end
      TC_SI3_ALT: kind_nxt = KIND_SI3;
      TC_SI4_ALT: kind_nxt = KIND_SI4;
      default:    kind_nxt = KIND_SI4;
    endcase
  end

  // control state: stage valids and rotation position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rot_r       <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move) begin
        rot_r <= rot_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_tc_r <= in_tc;
    end
    if (s1_move) begin
      out_kind_r <= kind_nxt;
      out_none_r <= none_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_si_kind   = out_kind_r;
  assign out_none_flag = out_none_r;

  // a none result always carries kind zero
  a_none_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_none_r) |-> (out_kind_r == KIND_SI1))
    else $error("none result with nonzero kind");

  // rotation position only moves when a slot enters the result register
  a_rot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_move |=> $stable(rot_r))
    else $error("rotation position changed without a slot");

  // input stalls only while the input register holds a slot
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

  // a held result stays valid while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_kind_r)))
    else $error("stalled result dropped");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcch_sysinfo_scheduler_core testbench
// Sends TC slots through the scheduler and checks every result against a
// local predictor of the slot to system information mapping, including the
// TC 4 rotation over the optional types. The optional type mask is changed
// between phases while the block is idle. Both handshake sides idle in
// random bursts, and the fourth and last random phases run without idling.
// ----------------------------------------------------------------------------
module testbench;
  import bcch_sched_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 4;
  localparam int SETTLE       = 4;       // idle margin after the slots are drained
  localparam int LIMIT_CYCLES = 200000;
  localparam int REPORT_MAX   = 10;
  localparam int RAND_PHASES  = 8;

  // one predicted result together with the rotation position it leaves
  typedef struct packed {
    tc_t   tc;
    kind_t kind;
    logic  none;
    rot_t  next_rot;
  } pick_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  tc_t   in_tc = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  kind_t out_si_kind;
  logic  out_none_flag;
  logic  cfg_wr_en = 1'b0;
  mask_t cfg_wr_data = '0;

  // predictor state, tracked at the same edges as the block
  mask_t present_mask = '0;
  rot_t  rot_pos = '0;

  tc_t   pending_slots[$];
  pick_t expected_picks[$];
  int    slots_queued = 0;
  int    slots_taken = 0;
  int    mismatch_count = 0;
  int    cycle_count = 0;
  int    gap_odds = 0;         // percent chance to start an idle burst
  int    send_gap = 0;
  int    stall_left = 0;
  logic  slot_taken = 1'b0;    // input transfer seen at the last rising edge

  bcch_sysinfo_scheduler_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_tc        (in_tc),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_si_kind  (out_si_kind),
    .out_none_flag(out_none_flag),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #CLK_HALF clk = ~clk;

  // expected system information type for one slot
  function automatic pick_t predict_pick(input tc_t tc, input mask_t mask, input rot_t rot);
    kind_t order[4];
    int    n;
    pick_t p;
    n = 0;
    p.tc = tc;
    p.kind = KIND_SI1;
    p.none = 1'b0;
    p.next_rot = rot;
    case (tc)
      TC_SI1:     p.kind = KIND_SI1;
      TC_SI2:     p.kind = KIND_SI2;
      TC_SI3:     p.kind = KIND_SI3;
      TC_SI4:     p.kind = KIND_SI4;
      TC_SI3_ALT: p.kind = KIND_SI3;
      TC_ROTATE: begin
        // 2ter needs 2bis, 2quater needs 2bis or 2ter
        if (mask[BIT_2TER] && mask[BIT_2BIS]) begin
          order[n] = KIND_SI2TER;
          n++;
        end
        if (mask[BIT_2QUATER] && (mask[BIT_2BIS] || mask[BIT_2TER])) begin
          order[n] = KIND_SI2QUATER;
          n++;
        end
        if (mask[BIT_13]) begin
          order[n] = KIND_SI13;
          n++;
        end
        if (mask[BIT_9]) begin
          order[n] = KIND_SI9;
          n++;
        end
        // empty list sends SI2 and keeps the position
        if (n == 0) begin
          p.kind = KIND_SI2;
        end else begin
          p.next_rot = rot_t'((int'(rot) + 1) % n);
          p.kind = order[p.next_rot];
        end
      end
      TC_SI2X: begin
        if (mask[BIT_2BIS]) begin
          p.kind = KIND_SI2BIS;
        end else if (mask[BIT_2TER]) begin
          p.kind = KIND_SI2TER;
        end else if (mask[BIT_2QUATER]) begin
          p.kind = KIND_SI2QUATER;
        end else begin
          p.none = 1'b1;
        end
      end
      default: p.kind = KIND_SI4;
    endcase
    return p;
  endfunction

  task automatic push_slot(input tc_t t);
    pending_slots.push_back(t);
    slots_queued++;
  endtask

  // wait until every queued slot has been taken and answered
  task automatic drain_slots();
    while (slots_taken != slots_queued || expected_picks.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mask(input mask_t m);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // slot sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || slot_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_slots.size() != 0 && $urandom_range(0, 99) < gap_odds) begin
        send_gap = $urandom_range(0, 15);
        in_valid <= 1'b0;
      end else if (pending_slots.size() != 0) begin
        in_valid <= 1'b1;
        in_tc <= pending_slots.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver stall bursts, none left over once idling is off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (gap_odds == 0) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < gap_odds) begin
      stall_left = $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // predict on input transfers, compare on result transfers
  always @(posedge clk) begin : monitor
    pick_t p;
    if (!rst_n) begin
      slot_taken <= 1'b0;
      present_mask = '0;
      rot_pos = '0;
    end else begin
      if (cfg_wr_en) present_mask = cfg_wr_data;
      slot_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        p = predict_pick(in_tc, present_mask, rot_pos);
        rot_pos = p.next_rot;
        expected_picks.push_back(p);
        slots_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_picks.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("unexpected result: kind %0d none %0d", out_si_kind, out_none_flag);
        end else begin
          p = expected_picks.pop_front();
          if (out_si_kind !== p.kind || out_none_flag !== p.none) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("mismatch tc %0d: kind exp %0d got %0d, none exp %0d got %0d",
                       p.tc, p.kind, out_si_kind, p.none, out_none_flag);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("bcch_sysinfo_scheduler_core regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int    n_items;
    mask_t m;
    tc_t   t;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    gap_odds = 15;

    // reset mask: fixed kinds, empty rotation list, nothing to send on TC 5
    for (int i = 0; i < 8; i++) push_slot(tc_t'(i));
    drain_slots();

    // all optional types: four entry rotation, TC 5 picks 2bis
    write_mask('1);
    push_slot(TC_ROTATE);
    push_slot(TC_ROTATE);
    push_slot(TC_ROTATE);
    push_slot(TC_SI2X);
    drain_slots();

    // two entry list while the position is left at the top
    m = '0;
    m[BIT_9] = 1'b1;
    m[BIT_13] = 1'b1;
    write_mask(m);
    push_slot(TC_ROTATE);
    push_slot(TC_ROTATE);
    drain_slots();

    // 2ter without 2bis: only 2quater rotates, TC 5 picks 2ter
    m = '0;
    m[BIT_2TER] = 1'b1;
    m[BIT_2QUATER] = 1'b1;
    write_mask(m);
    push_slot(TC_ROTATE);
    push_slot(TC_SI2X);
    drain_slots();

    // 2quater alone: rotation list empty, TC 5 picks 2quater
    m = '0;
    m[BIT_2QUATER] = 1'b1;
    write_mask(m);
    push_slot(TC_ROTATE);
    push_slot(TC_SI2X);
    drain_slots();

    // 2ter alone
    m = '0;
    m[BIT_2TER] = 1'b1;
    write_mask(m);
    push_slot(TC_SI2X);
    push_slot(TC_ROTATE);
    drain_slots();

    // random phases, rotation slots weighted up, fourth and last phases without idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) m = '1;
      else if (ph == 1) m = '0;
      else m = mask_t'($urandom_range(0, 31));
      gap_odds = (ph == 3 || ph == RAND_PHASES - 1) ? 0 : $urandom_range(10, 40);
      write_mask(m);
      n_items = $urandom_range(75, 100);
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 3) == 0) t = TC_ROTATE;
        else t = tc_t'($urandom_range(0, 7));
        push_slot(t);
      end
      drain_slots();
    end

    repeat (SETTLE) @(negedge clk);
    if (mismatch_count == 0 && expected_picks.size() == 0)
      $display("bcch_sysinfo_scheduler_core regression: pass");
    else
      $display("bcch_sysinfo_scheduler_core regression: fail");
    $finish;
  end

endmodule
